>>> rtl/aapr_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the axis-angle rotation core
package aapr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS  = 30;
	localparam int ROOT_STEPS    = 32;
	localparam int DIV_BITS      = 32;
	localparam int LANES         = 9;
	localparam int CW            = 34;

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
	localparam logic [26:0]          DEG_TO_RAD  = 27'd74961321;
	localparam logic signed [CW:0]   ONE_Q30     = (CW+1)'(1 << 30);

	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] den;
		logic [31:0] quo;
		logic        neg;
	} lane_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               zero;
	} side_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic               zero;
		logic               sat;
	} res_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'h3243F6A8;
			5'd1:  v = 30'h1DAC6705;
			5'd2:  v = 30'h0FADBAFC;
			5'd3:  v = 30'h07F56EA6;
			5'd4:  v = 30'h03FEAB76;
			5'd5:  v = 30'h01FFD55B;
			5'd6:  v = 30'h00FFFAAA;
			5'd7:  v = 30'h007FFF55;
			5'd8:  v = 30'h003FFFEA;
			5'd9:  v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			5'd24: v = 30'h0000003F;
			5'd25: v = 30'h0000001F;
			5'd26: v = 30'h0000000F;
			5'd27: v = 30'h00000008;
			5'd28: v = 30'h00000004;
			5'd29: v = 30'h00000002;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/aapr_div.sv
// Multi-lane restoring divider pipeline, one quotient bit per stage, with side payload
module aapr_div import aapr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  lane_t [LANES-1:0]       in_lane,
	input  side_t                   in_side,
	output logic                    out_vld,
	output lane_t [LANES-1:0]       out_lane,
	output side_t                   out_side
);

	lane_t [LANES-1:0]   lane_s [DIV_BITS];
	side_t               side_s [DIV_BITS];
	logic [DIV_BITS-1:0] vld_s;

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_stg
		lane_t [LANES-1:0] src;
		lane_t [LANES-1:0] nxt;
		side_t             sside;
		logic              svld;

		if (k == 0) begin : g_first
			assign src   = in_lane;
			assign sside = in_side;
			assign svld  = in_vld;
		end else begin : g_next
			assign src   = lane_s[k-1];
			assign sside = side_s[k-1];
			assign svld  = vld_s[k-1];
		end

		always_comb begin
			logic [63:0] trial;
			nxt = src;
			for (int l = 0; l < LANES; l++) begin
				trial = 64'(src[l].den) << (DIV_BITS-1-k);
				if (src[l].rem >= trial) begin
					nxt[l].rem = src[l].rem - trial;
					nxt[l].quo[DIV_BITS-1-k] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[k] <= nxt;
				side_s[k] <= sside;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= svld;
			end
		end
	end

	assign out_vld  = vld_s[DIV_BITS-1];
	assign out_lane = lane_s[DIV_BITS-1];
	assign out_side = side_s[DIV_BITS-1];

endmodule

>>> rtl/axis_angle_point_rotation_core.sv
// Top level of the axis-angle (Rodrigues) point rotation core
//
// Slave stream takes one point, a rotation axis of any length and an angle in degrees per
// transaction; master stream returns the rotated point with two flags in tuser.
// Angle reduction uses NQ modulo-360 subtract stages, where NQ is
// ceil(log2(2*(floor(2^31/(360*2^FRAC_BITS))+1))). Throughput is one transaction per cycle
// while no output stall holds the pipeline. Most of the pipeline depth lies in the
// 32-stage CORDIC/square-root section and the 32-stage divider.
// A zero axis passes the point through with axis_zero set; a clamped coordinate sets
// saturated.
// Reset clears every valid bit; payload registers are left as they are.
// When the receiver stalls, the finished result holds on the master port and the next one
// drops into a one-entry skid register while the pipeline advances a last time; then
// s_axis_tready falls and the whole pipeline holds until the master side drains.
// Nothing is lost or repeated across a stall.
module axis_angle_point_rotation_core import aapr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// point_x, point_y, point_z, axis_x, axis_y, axis_z, angle_deg
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// rot_x, rot_y, rot_z
	output logic [95:0]  m_axis_tdata,
	// axis_zero, saturated
	output logic [1:0]   m_axis_tuser
);

	localparam logic [63:0] FULL    = 64'(360) << FRAC_BITS;
	localparam logic [63:0] QUARTER = 64'(90) << FRAC_BITS;
	localparam logic [63:0] BIAS_K  = (64'h8000_0000 / FULL) + 64'd1;
	localparam int          NQ      = $clog2(int'(BIAS_K) * 2);
	localparam int          RW      = 34;
	localparam logic [RW-1:0] BIAS  = RW'(BIAS_K * FULL);
	localparam logic [RW-1:0] Q1    = RW'(QUARTER);
	localparam logic [RW-1:0] Q2    = RW'(QUARTER * 2);
	localparam logic [RW-1:0] Q3    = RW'(QUARTER * 3);
	localparam logic [RW-1:0] Q4    = RW'(FULL);
	localparam int          TW      = FRAC_BITS + 7;
	localparam int          PW      = TW + 27;
	localparam int          MW      = 34;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic [30:0]        xx;
		logic [30:0]        yy;
		logic [30:0]        zz;
		logic signed [31:0] axy;
		logic signed [31:0] axz;
		logic signed [31:0] ayz;
	} geo_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [63:0]          n;
		logic [63:0]          res;
		logic                 nc;
		logic                 ns;
		logic                 zero;
		logic [31:0]          len2;
		geo_t                 g;
	} itr_t;

	logic adv;
	logic out_v_q, skd_v_q;
	res_t out_q, skd_q;

	assign adv           = ~skd_v_q;
	assign s_axis_tready = adv;

	// input unpacking
	logic signed [31:0] in_px, in_py, in_pz, in_ang;
	logic signed [15:0] in_ax, in_ay, in_az;
	logic signed [31:0] sq_x, sq_y, sq_z, pr_xy, pr_xz, pr_yz;

	assign in_px  = s_axis_tdata[31:0];
	assign in_py  = s_axis_tdata[63:32];
	assign in_pz  = s_axis_tdata[95:64];
	assign in_ax  = s_axis_tdata[111:96];
	assign in_ay  = s_axis_tdata[127:112];
	assign in_az  = s_axis_tdata[143:128];
	assign in_ang = s_axis_tdata[175:144];
	assign sq_x   = in_ax * in_ax;
	assign sq_y   = in_ay * in_ay;
	assign sq_z   = in_az * in_az;
	assign pr_xy  = in_ax * in_ay;
	assign pr_xz  = in_ax * in_az;
	assign pr_yz  = in_ay * in_az;

	// s1 and angle reduction
	logic [RW-1:0] red_s  [NQ+1];
	geo_t          redg_s [NQ+1];
	logic [NQ:0]   redv_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s[0]      <= BIAS + {{(RW-32){in_ang[31]}}, in_ang};
			redg_s[0].px  <= in_px;
			redg_s[0].py  <= in_py;
			redg_s[0].pz  <= in_pz;
			redg_s[0].ax  <= in_ax;
			redg_s[0].ay  <= in_ay;
			redg_s[0].az  <= in_az;
			redg_s[0].xx  <= sq_x[30:0];
			redg_s[0].yy  <= sq_y[30:0];
			redg_s[0].zz  <= sq_z[30:0];
			redg_s[0].axy <= pr_xy;
			redg_s[0].axz <= pr_xz;
			redg_s[0].ayz <= pr_yz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			redv_s[0] <= 1'b0;
		end else if (adv) begin
			redv_s[0] <= s_axis_tvalid;
		end
	end

	for (genvar j = 0; j < NQ; j++) begin : g_red
		localparam logic [RW-1:0] TRIAL = RW'(FULL << (NQ-1-j));

		always_ff @(posedge clk) begin
			if (adv) begin
				red_s[j+1]  <= (red_s[j] >= TRIAL) ? red_s[j] - TRIAL : red_s[j];
				redg_s[j+1] <= redg_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				redv_s[j+1] <= 1'b0;
			end else if (adv) begin
				redv_s[j+1] <= redv_s[j];
			end
		end
	end

	// s2: quadrant fold and squared length
	logic [TW-1:0] t_s2;
	logic          nc_s2, ns_s2, zero_s2, v_s2;
	logic [31:0]   len2_s2;
	geo_t          g_s2;
	logic [RW-1:0] fold_t;
	logic          fold_nc, fold_ns;
	logic [31:0]   fold_len2;

	always_comb begin
		fold_nc = 1'b0;
		fold_ns = 1'b0;
		if (red_s[NQ] <= Q1) begin
			fold_t = red_s[NQ];
		end else if (red_s[NQ] <= Q2) begin
			fold_t  = Q2 - red_s[NQ];
			fold_nc = 1'b1;
		end else if (red_s[NQ] <= Q3) begin
			fold_t  = red_s[NQ] - Q2;
			fold_nc = 1'b1;
			fold_ns = 1'b1;
		end else begin
			fold_t  = Q4 - red_s[NQ];
			fold_ns = 1'b1;
		end
		fold_len2 = 32'(redg_s[NQ].xx) + 32'(redg_s[NQ].yy) + 32'(redg_s[NQ].zz);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2    <= fold_t[TW-1:0];
			nc_s2   <= fold_nc;
			ns_s2   <= fold_ns;
			len2_s2 <= fold_len2;
			zero_s2 <= (fold_len2 == 32'd0);
			g_s2    <= redg_s[NQ];
		end
	end

	// s3 (first entry of the iteration array): radians and start vectors
	itr_t              itr_s [ROOT_STEPS+1];
	logic [ROOT_STEPS:0] itrv_s;
	logic [PW-1:0]     rad_sum;

	assign rad_sum = PW'(t_s2) * PW'(DEG_TO_RAD) + (PW'(1) << (FRAC_BITS+1));

	always_ff @(posedge clk) begin
		if (adv) begin
			itr_s[0].x    <= CORDIC_GAIN;
			itr_s[0].y    <= '0;
			itr_s[0].z    <= CW'(rad_sum >> (FRAC_BITS+2));
			itr_s[0].n    <= {len2_s2, 32'd0};
			itr_s[0].res  <= '0;
			itr_s[0].nc   <= nc_s2;
			itr_s[0].ns   <= ns_s2;
			itr_s[0].zero <= zero_s2;
			itr_s[0].len2 <= len2_s2;
			itr_s[0].g    <= g_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			itrv_s[0] <= 1'b0;
		end else if (adv) begin
			v_s2      <= redv_s[NQ];
			itrv_s[0] <= v_s2;
		end
	end

	// CORDIC rotation and square root, one step per stage
	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_itr
		itr_t nxt;

		always_comb begin
			logic signed [CW-1:0] cx, cy, cz, dx, dy, at;
			logic [63:0]          bitv, tr;
			nxt  = itr_s[j];
			cx   = itr_s[j].x;
			cy   = itr_s[j].y;
			cz   = itr_s[j].z;
			dx   = cy >>> j;
			dy   = cx >>> j;
			at   = $signed({4'b0, atan_q30(5'(j))});
			bitv = 64'(1) << (62 - 2*j);
			tr   = itr_s[j].res + bitv;
			if (j < CORDIC_STEPS) begin
				if (!cz[CW-1]) begin
					nxt.x = cx - dx;
					nxt.y = cy + dy;
					nxt.z = cz - at;
				end else begin
					nxt.x = cx + dx;
					nxt.y = cy - dy;
					nxt.z = cz + at;
				end
			end
			if (itr_s[j].n >= tr) begin
				nxt.n   = itr_s[j].n - tr;
				nxt.res = (itr_s[j].res >> 1) + bitv;
			end else begin
				nxt.res = itr_s[j].res >> 1;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				itr_s[j+1] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				itrv_s[j+1] <= 1'b0;
			end else if (adv) begin
				itrv_s[j+1] <= itrv_s[j];
			end
		end
	end

	// s4: signed sine and cosine
	logic signed [CW-1:0] c_s4, s_s4;
	logic signed [CW:0]   omc_s4;
	logic [31:0]          root_s4, len2_s4;
	logic                 zero_s4, v_s4;
	geo_t                 g_s4;
	logic signed [CW-1:0] cs_c, cs_s;

	assign cs_c = itr_s[ROOT_STEPS].nc ? -itr_s[ROOT_STEPS].x : itr_s[ROOT_STEPS].x;
	assign cs_s = itr_s[ROOT_STEPS].ns ? -itr_s[ROOT_STEPS].y : itr_s[ROOT_STEPS].y;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4    <= cs_c;
			s_s4    <= cs_s;
			omc_s4  <= ONE_Q30 - cs_c;
			root_s4 <= itr_s[ROOT_STEPS].res[31:0];
			len2_s4 <= itr_s[ROOT_STEPS].len2;
			zero_s4 <= itr_s[ROOT_STEPS].zero;
			g_s4    <= itr_s[ROOT_STEPS].g;
		end
	end

	// s5: matrix numerators
	logic signed [63:0] num_s5 [LANES];
	logic [31:0]        len2_s5, root_s5;
	side_t              side_s5;
	logic               v_s5;
	logic signed [32:0] yz_sum, xz_sum, xy_sum;

	assign yz_sum = $signed({1'b0, 32'(g_s4.yy) + 32'(g_s4.zz)});
	assign xz_sum = $signed({1'b0, 32'(g_s4.xx) + 32'(g_s4.zz)});
	assign xy_sum = $signed({1'b0, 32'(g_s4.xx) + 32'(g_s4.yy)});

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5[0]    <= $signed({33'd0, g_s4.xx} << 30) + yz_sum * c_s4;
			num_s5[1]    <= $signed({33'd0, g_s4.yy} << 30) + xz_sum * c_s4;
			num_s5[2]    <= $signed({33'd0, g_s4.zz} << 30) + xy_sum * c_s4;
			num_s5[3]    <= g_s4.axy * omc_s4;
			num_s5[4]    <= g_s4.axz * omc_s4;
			num_s5[5]    <= g_s4.ayz * omc_s4;
			num_s5[6]    <= (g_s4.ax * s_s4) <<< 16;
			num_s5[7]    <= (g_s4.ay * s_s4) <<< 16;
			num_s5[8]    <= (g_s4.az * s_s4) <<< 16;
			len2_s5      <= len2_s4;
			root_s5      <= root_s4;
			side_s5.px   <= g_s4.px;
			side_s5.py   <= g_s4.py;
			side_s5.pz   <= g_s4.pz;
			side_s5.zero <= zero_s4;
		end
	end

	// s6: magnitudes with half-divisor bias
	lane_t [LANES-1:0] pre_s6;
	side_t             side_s6;
	logic              v_s6;
	lane_t [LANES-1:0] pre_nxt;

	always_comb begin
		logic [31:0] den;
		logic [63:0] mag;
		for (int l = 0; l < LANES; l++) begin
			den = (l < 6) ? len2_s5 : root_s5;
			mag = num_s5[l][63] ? 64'(-num_s5[l]) : 64'(num_s5[l]);
			pre_nxt[l].rem = mag + 64'(den >> 1);
			pre_nxt[l].den = den;
			pre_nxt[l].quo = '0;
			pre_nxt[l].neg = num_s5[l][63];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s6  <= pre_nxt;
			side_s6 <= side_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s4 <= itrv_s[ROOT_STEPS];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// dividers
	lane_t [LANES-1:0] dq;
	side_t             dside;
	logic              dv;

	aapr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (v_s6),
		.in_lane  (pre_s6),
		.in_side  (side_s6),
		.out_vld  (dv),
		.out_lane (dq),
		.out_side (dside)
	);

	// s7: matrix entries
	logic signed [MW-1:0] m_s7 [3][3];
	side_t                side_s7;
	logic                 v_s7;
	logic signed [32:0]   qs [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			qs[l] = dq[l].neg ? -$signed({1'b0, dq[l].quo}) : $signed({1'b0, dq[l].quo});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s7[0][0] <= MW'(qs[0]);
			m_s7[1][1] <= MW'(qs[1]);
			m_s7[2][2] <= MW'(qs[2]);
			m_s7[0][1] <= MW'(qs[3]) - MW'(qs[8]);
			m_s7[1][0] <= MW'(qs[3]) + MW'(qs[8]);
			m_s7[0][2] <= MW'(qs[4]) + MW'(qs[7]);
			m_s7[2][0] <= MW'(qs[4]) - MW'(qs[7]);
			m_s7[1][2] <= MW'(qs[5]) - MW'(qs[6]);
			m_s7[2][1] <= MW'(qs[5]) + MW'(qs[6]);
			side_s7    <= dside;
		end
	end

	// s8: entry times coordinate
	logic signed [MW+31:0] prod_s8 [3][3];
	side_t                 side_s8;
	logic                  v_s8;
	logic signed [31:0]    pt [3];

	assign pt[0] = side_s7.px;
	assign pt[1] = side_s7.py;
	assign pt[2] = side_s7.pz;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s8[i][k] <= m_s7[i][k] * pt[k];
				end
			end
			side_s8 <= side_s7;
		end
	end

	// s9: row sums, rounded
	logic signed [MW+5:0] sum_s9 [3];
	side_t                side_s9;
	logic                 v_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sum_s9[i] <= (MW+6)'(((MW+34)'(prod_s8[i][0]) + (MW+34)'(prod_s8[i][1])
					+ (MW+34)'(prod_s8[i][2]) + (MW+34)'(1 << 29)) >>> 30);
			end
			side_s9 <= side_s8;
		end
	end

	// s10: clamp and zero-axis bypass
	res_t               res_s10;
	logic               v_s10;
	logic signed [31:0] clp [3];
	logic [2:0]         hit;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sum_s9[i] > (MW+6)'(64'sd2147483647)) begin
				clp[i] = 32'sh7FFFFFFF;
				hit[i] = 1'b1;
			end else if (sum_s9[i] < -(MW+6)'(64'sd2147483648)) begin
				clp[i] = 32'sh80000000;
				hit[i] = 1'b1;
			end else begin
				clp[i] = sum_s9[i][31:0];
				hit[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s9.zero) begin
				res_s10.rx   <= side_s9.px;
				res_s10.ry   <= side_s9.py;
				res_s10.rz   <= side_s9.pz;
				res_s10.zero <= 1'b1;
				res_s10.sat  <= 1'b0;
			end else begin
				res_s10.rx   <= clp[0];
				res_s10.ry   <= clp[1];
				res_s10.rz   <= clp[2];
				res_s10.zero <= 1'b0;
				res_s10.sat  <= |hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s7  <= dv;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skd_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skd_v_q) begin
				out_v_q <= 1'b1;
				skd_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s10 & adv;
			end
		end else if (v_s10 && adv) begin
			skd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			if (skd_v_q) begin
				out_q <= skd_q;
			end else begin
				out_q <= res_s10;
			end
		end else if (v_s10 && adv) begin
			skd_q <= res_s10;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_q.rz, out_q.ry, out_q.rx};
	assign m_axis_tuser  = {out_q.sat, out_q.zero};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skd_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skd_v_q) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("skid entry filled without an output stall");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("zero axis result flagged as saturated");

endmodule

>>> tb/sv/tb_axis_angle_point_rotation_core.sv
// Testbench for the axis-angle point rotation core: predicted rotations against the RTL
module tb_axis_angle_point_rotation_core;
	import aapr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint Q30 = 64'sd1 << 30;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [15:0] ax, ay, az;
		logic signed [31:0] ang;
	} job_t;

	typedef struct {
		logic signed [31:0] rx, ry, rz;
		logic               zero, sat;
	} rot_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [95:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	rot_t   pending_rot[$];
	int     errors = 0;
	int     n_sent = 0;
	int     n_recv = 0;
	int     n_zero = 0;
	int     n_sat = 0;
	bit     stall_on = 1;

	axis_angle_point_rotation_core uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		#40ms;
		$display("tb_axis_angle_point_rotation_core NOT OK");
		$finish;
	end

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint round_div(longint n, longint d);
		longint unsigned mag, q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic trig_of_degrees(input longint deg, output longint c, output longint s);
		longint full, qtr, red, t, x, y, z, dx, dy;
		bit nc, ns;
		full = 64'sd360 << FB;
		qtr = 64'sd90 << FB;
		nc = 0;
		ns = 0;
		red = deg % full;
		if (red < 0)
			red += full;
		if (red <= qtr) begin
			t = red;
		end else if (red <= 2 * qtr) begin
			t = 2 * qtr - red; nc = 1;
		end else if (red <= 3 * qtr) begin
			t = red - 2 * qtr; nc = 1; ns = 1;
		end else begin
			t = full - red; ns = 1;
		end
		z = longint'((longint'(t) * 64'd74961321 + (64'd1 << (FB + 1))) >> (FB + 2));
		x = CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
			end else begin
				x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
			end
		end
		c = nc ? -x : x;
		s = ns ? -y : y;
	endtask

	task automatic predict_rotation(input job_t j, output rot_t r);
		longint p[3], m[3][3], ax, ay, az, xx, yy, zz, len2, root, c, s, omc;
		longint cxy, cxz, cyz, sxa, sya, sza, acc, v;
		p[0] = j.px; p[1] = j.py; p[2] = j.pz;
		ax = j.ax; ay = j.ay; az = j.az;
		xx = ax * ax; yy = ay * ay; zz = az * az;
		len2 = xx + yy + zz;
		r.sat = 0;
		if (len2 == 0) begin
			r.rx = j.px; r.ry = j.py; r.rz = j.pz;
			r.zero = 1;
			return;
		end
		r.zero = 0;
		trig_of_degrees(longint'(j.ang), c, s);
		omc = Q30 - c;
		root = longint'(int_sqrt(longint'(len2) << 32));
		cxy = round_div(ax * ay * omc, len2);
		cxz = round_div(ax * az * omc, len2);
		cyz = round_div(ay * az * omc, len2);
		sxa = round_div(ax * s * 65536, root);
		sya = round_div(ay * s * 65536, root);
		sza = round_div(az * s * 65536, root);
		m[0][0] = round_div(xx * Q30 + (yy + zz) * c, len2);
		m[1][1] = round_div(yy * Q30 + (xx + zz) * c, len2);
		m[2][2] = round_div(zz * Q30 + (xx + yy) * c, len2);
		m[0][1] = cxy - sza; m[1][0] = cxy + sza;
		m[0][2] = cxz + sya; m[2][0] = cxz - sya;
		m[1][2] = cyz - sxa; m[2][1] = cyz + sxa;
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2];
			v = floor_shift(acc + (64'sd1 << 29), 30);
			if (v > 64'sd2147483647) begin
				v = 64'sd2147483647; r.sat = 1;
			end
			if (v < -64'sd2147483648) begin
				v = -64'sd2147483648; r.sat = 1;
			end
			if (i == 0) r.rx = v[31:0];
			else if (i == 1) r.ry = v[31:0];
			else r.rz = v[31:0];
		end
	endtask

	task automatic send_point(input job_t j);
		rot_t r;
		int gap;
		gap = stall_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		predict_rotation(j, r);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {j.ang, j.az, j.ay, j.ax, j.pz, j.py, j.px};
		do @(posedge clk); while (!s_axis_tready);
		pending_rot.push_back(r);
		n_sent++;
	endtask

	// receiver: draw a stall count per transaction
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			wait_n = stall_on ? $urandom_range(0, 15) : 0;
			if (wait_n > 0) begin
				m_axis_tready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		rot_t e, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.rx = m_axis_tdata[31:0];
			got.ry = m_axis_tdata[63:32];
			got.rz = m_axis_tdata[95:64];
			got.zero = m_axis_tuser[0];
			got.sat = m_axis_tuser[1];
			n_recv++;
			if (pending_rot.size() == 0) begin
				errors++;
				$display("%t unexpected result rx=%h", $realtime, got.rx);
			end else begin
				e = pending_rot.pop_front();
				n_zero += e.zero;
				n_sat += e.sat;
				if (got.rx !== e.rx || got.ry !== e.ry || got.rz !== e.rz
						|| got.zero !== e.zero || got.sat !== e.sat) begin
					errors++;
					$display("%t mismatch exp %h %h %h z%b s%b got %h %h %h z%b s%b",
						$realtime, e.rx, e.ry, e.rz, e.zero, e.sat,
						got.rx, got.ry, got.rz, got.zero, got.sat);
				end
			end
		end
	end

	function automatic job_t rand_job(bit wide);
		job_t j;
		j.px = wide ? $urandom : $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
		j.py = wide ? $urandom : $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
		j.pz = wide ? $urandom : $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
		j.ax = 16'($urandom);
		j.ay = 16'($urandom);
		j.az = 16'($urandom);
		case ($urandom_range(0, 3))
			0: j.ax = $signed(16'($urandom_range(0, 8))) - 16'sd4;
			1: j.ay = 0;
			default: ;
		endcase
		j.ang = ($urandom_range(0, 3) == 0) ? $urandom
			: $signed($urandom_range(0, 720 << 16)) - (32'sd360 <<< 16);
		return j;
	endfunction

	task automatic test_directed();
		job_t j;
		logic signed [31:0] angs[8];
		angs = '{0, 90 << 16, 180 << 16, 270 << 16, 360 << 16, -(90 << 16),
			32'h7FFFFFFF, 32'h80000000};
		j = '{32'h00010000, 32'h00020000, 32'hFFFD0000, 0, 0, 0, 45 << 16};
		send_point(j);
		j.ax = 0; j.ay = 0; j.az = 0; j.px = 32'h80000000; j.py = 32'h7FFFFFFF;
		send_point(j);
		foreach (angs[i]) begin
			j = '{32'h00030000, 32'hFFFF0000, 32'h00020000, 16'sd1, 16'sd2, 16'sd3, angs[i]};
			send_point(j);
		end
		j = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd1, 16'sd0, 16'sd0, 45 << 16};
		send_point(j);
		j = '{32'h80000000, 32'h80000000, 32'h80000000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1234567};
		send_point(j);
		j = '{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 16'sh8000, 16'sh8000, 16'sh8000, 0};
		send_point(j);
		j = '{32'hFFFFFFFF, 32'h00000001, 32'h00000000, 16'sd0, 16'sd0, -16'sd1, 30 << 16};
		send_point(j);
	endtask

	task automatic test_random(int n);
		repeat (n)
			send_point(rand_job($urandom_range(0, 4) == 0));
	endtask

	task automatic test_full_rate(int n);
		stall_on = 0;
		repeat (n)
			send_point(rand_job(0));
		stall_on = 1;
	endtask

	initial begin
		int guard;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(900);
		test_full_rate(150);
		test_random(100);
		s_axis_tvalid <= 0;
		guard = 0;
		while (pending_rot.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		$display("sent %0d points, received %0d: %0d zero-axis, %0d saturated",
			n_sent, n_recv, n_zero, n_sat);
		if (errors == 0 && pending_rot.size() == 0)
			$display("tb_axis_angle_point_rotation_core OK");
		else
			$display("tb_axis_angle_point_rotation_core NOT OK");
		$finish;
	end

endmodule
